// ----- rtl/core/ffha_pkg.sv -----
// Shared types, codes and default constants of the first-fit heap allocator.
package ffha_pkg;

   localparam int DEF_HEAP_BYTES   = 4096;
   localparam int DEF_ALIGN_BYTES  = 8;
   localparam int DEF_HEADER_BYTES = 24;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OOM     = 2'd1;
   localparam logic [1:0] ST_ZERO    = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic        command;
      logic [11:0] request_size;
      logic [11:0] payload_address;
   } req_word_type;

   typedef struct packed {
      logic [11:0] result_address;
      logic [1:0]  status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      WR_INIT,
      WR_HEAD,
      WR_REST,
      WR_MARK,
      WR_MERGE
   } wr_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      logic       rd_zero;
      logic       load_cur;
      logic       calc_need;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       respond;
      logic       rsp_use_addr;
      logic [1:0] rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_free;
      logic req_zero;
      logic req_low;
      logic cur_fit;
      logic split;
      logic nxt_end;
      logic cur_hit;
      logic cur_past;
      logic both_free;
   } dp_stat_type;

endpackage

// ----- rtl/core/first_fit_heap_allocator_top.sv -----
// Top level of the first-fit heap allocator with block split and free-run merge.
//
// The allocator keeps a heap of HEAP_BYTES bytes as a chain of blocks, each
// led by a HEADER_BYTES header, in a header store indexed by byte offset. A
// command word is taken when start is high and busy is low. Allocate rounds
// the size up to ALIGN_BYTES and walks the chain from offset zero to the
// first free block that fits, splitting off the remainder when it can hold a
// header plus one alignment unit. Free walks the chain to the block whose
// payload is given, marks it free, then walks the whole chain again merging
// adjacent free blocks. The header store has a single read port with a
// registered output, so each visited header is read into registers before
// it is examined. A free walks the chain once for the search and once
// more for the merge pass. Zero-size allocates and frees of
// an address below the first payload never walk the chain; their result word
// comes out in the cycle right after they are taken. The result word appears
// on rsp_word for exactly one cycle with rsp_valid high; the receiver cannot
// stall it. During that cycle the block is already idle, so the next command
// can be taken at the edge that ends it. After reset, busy stays high for one
// cycle while the first header is written.
module first_fit_heap_allocator_top #(
   parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
   parameter int ALIGN_BYTES  = ffha_pkg::DEF_ALIGN_BYTES,
   parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ffha_pkg::req_word_type req_word,
   output ffha_pkg::rsp_word_type rsp_word,
   output logic                   rsp_valid
);
   import ffha_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // The sequencer decides what the datapath does each cycle.
   ffha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the header store and the walk registers.
   ffha_datapath #(
      .HEAP_BYTES   (HEAP_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid)
   );

   // Every accepted word either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted word neither answered nor in progress");

   // Only a successful allocate returns a nonzero address.
   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != ST_OK) |-> (rsp_word.result_address == 12'd0))
      else $error("failed command returned an address");

   // A nonzero address only ever comes with an ok status.
   a_grant_past_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.result_address != 12'd0)
      |-> (rsp_word.status == ST_OK))
      else $error("address returned with a bad status");

endmodule

// ----- rtl/core/ffha_datapath.sv -----
// Header store, chain-walk registers and result register of the allocator.
module ffha_datapath #(
   parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
   parameter int ALIGN_BYTES  = ffha_pkg::DEF_ALIGN_BYTES,
   parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ffha_pkg::req_word_type  req_word,
   input  ffha_pkg::ctrl_cmd_type  cmd,
   output ffha_pkg::dp_stat_type   stat,
   output ffha_pkg::rsp_word_type  rsp_word,
   output logic                    rsp_valid
);
   import ffha_pkg::*;

   localparam int AW  = $clog2(HEAP_BYTES);
   localparam int CW  = ((AW > 13) ? AW : 13) + 2;
   localparam int SH  = 20;
   localparam int RW  = SH + 1;
   localparam int XW  = 13;
   localparam logic [RW-1:0] RECIP = RW'((2**SH + ALIGN_BYTES - 1) / ALIGN_BYTES);
   localparam logic [CW-1:0] HDR   = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] ALN   = CW'(ALIGN_BYTES);
   localparam logic [CW-1:0] HEAP  = CW'(HEAP_BYTES);

   logic [AW:0]    store [HEAP_BYTES];   // {free, size}

   logic [AW-1:0]  cur_off_ff;
   logic [AW-1:0]  cur_size_ff;
   logic           cur_free_ff;
   logic [AW-1:0]  rd_addr_ff;
   logic [AW-1:0]  rd_size_ff;
   logic           rd_free_ff;
   logic [XW-1:0]  quot_ff;
   logic [CW-1:0]  need_ff;
   logic [11:0]    target_ff;
   logic           rsp_valid_ff;
   rsp_word_type   rsp_ff;

   logic [CW-1:0]  nxt;
   logic [CW-1:0]  rest;
   logic [XW-1:0]  round_up;
   logic [XW+RW-1:0] prod;
   logic [AW-1:0]  rd_addr_in;
   logic [AW-1:0]  wr_addr;
   logic [AW:0]    wr_data;
   logic [AW-1:0]  merged;
   logic [CW-1:0]  cur_size_w;

   assign cur_size_w = CW'(cur_size_ff);
   assign nxt        = CW'(cur_off_ff) + HDR + cur_size_w;
   assign rest       = CW'(cur_off_ff) + HDR + need_ff;
   assign merged     = AW'(cur_size_w + HDR + CW'(rd_size_ff));
   assign round_up   = XW'(req_word.request_size) + XW'(ALIGN_BYTES - 1);
   assign prod       = XW'(round_up) * RECIP;
   assign rd_addr_in = cmd.rd_zero ? '0 : AW'(nxt);

   assign stat.req_free  = (req_word.command == CMD_FREE);
   assign stat.req_zero  = (req_word.request_size == 12'd0);
   assign stat.req_low   = (CW'(req_word.payload_address) < HDR);
   assign stat.cur_fit   = cur_free_ff && (cur_size_w >= need_ff);
   assign stat.split     = (cur_size_w >= need_ff + HDR + ALN);
   assign stat.nxt_end   = (nxt >= HEAP);
   assign stat.cur_hit   = (CW'(cur_off_ff) == CW'(target_ff));
   assign stat.cur_past  = (CW'(cur_off_ff) > CW'(target_ff));
   assign stat.both_free = cur_free_ff && rd_free_ff;

   always_comb begin
      wr_addr = cur_off_ff;
      wr_data = {1'b1, cur_size_ff};
      case (cmd.wr_sel)
         WR_INIT: begin
            wr_addr = '0;
            wr_data = {1'b1, AW'(HEAP - HDR)};
         end
         WR_HEAD: begin
            wr_data = {1'b0, stat.split ? AW'(need_ff) : cur_size_ff};
         end
         WR_REST: begin
            wr_addr = AW'(rest);
            wr_data = {1'b1, AW'(cur_size_w - need_ff - HDR)};
         end
         WR_MARK: begin
            wr_data = {1'b1, cur_size_ff};
         end
         WR_MERGE: begin
            wr_data = {cur_free_ff, merged};
         end
         default: begin
            wr_data = {1'b1, cur_size_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         {rd_free_ff, rd_size_ff} <= store[rd_addr_in];
         rd_addr_ff <= rd_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         quot_ff   <= XW'(prod >> SH);
         target_ff <= req_word.payload_address - 12'(HEADER_BYTES);
      end
      if (cmd.calc_need) begin
         need_ff <= CW'(quot_ff * ALN);
      end
      if (cmd.load_cur) begin
         cur_off_ff  <= rd_addr_ff;
         cur_size_ff <= rd_size_ff;
         cur_free_ff <= rd_free_ff;
      end else if (cmd.wr_en && cmd.wr_sel == WR_MERGE) begin
         cur_size_ff <= merged;
      end
      if (cmd.respond) begin
         rsp_ff.status         <= cmd.rsp_status;
         rsp_ff.result_address <= cmd.rsp_use_addr ? 12'(CW'(cur_off_ff) + HDR) : 12'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_word  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/ffha_ctrl.sv -----
// Sequencer that walks the header chain for allocate, free and merge.
module ffha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ffha_pkg::dp_stat_type  stat,
   output ffha_pkg::ctrl_cmd_type cmd
);
   import ffha_pkg::*;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_LOAD,
      S_ACHK,
      S_AREST,
      S_FCHK,
      S_MSTART,
      S_MLOAD,
      S_MCHK,
      S_MNXT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      free_ff;
   logic      free_in;

   always_comb begin
      cmd      = '0;
      cmd.wr_sel = WR_INIT;
      state_in = state_ff;
      free_in  = free_ff;
      case (state_ff)
         S_INIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_INIT;
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               free_in      = stat.req_free;
               if (!stat.req_free && stat.req_zero) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = ST_ZERO;
               end else if (stat.req_free && stat.req_low) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = ST_IGNORED;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_zero = 1'b1;
                  state_in    = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            cmd.load_cur  = 1'b1;
            cmd.calc_need = 1'b1;
            state_in      = free_ff ? S_FCHK : S_ACHK;
         end
         S_ACHK: begin
            if (stat.cur_fit) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_HEAD;
               if (stat.split) begin
                  state_in = S_AREST;
               end else begin
                  cmd.respond      = 1'b1;
                  cmd.rsp_use_addr = 1'b1;
                  cmd.rsp_status   = ST_OK;
                  state_in         = S_IDLE;
               end
            end else if (stat.nxt_end) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_OOM;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_LOAD;
            end
         end
         S_AREST: begin
            cmd.wr_en        = 1'b1;
            cmd.wr_sel       = WR_REST;
            cmd.respond      = 1'b1;
            cmd.rsp_use_addr = 1'b1;
            cmd.rsp_status   = ST_OK;
            state_in         = S_IDLE;
         end
         S_FCHK: begin
            if (stat.cur_past) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_IGNORED;
               state_in       = S_IDLE;
            end else if (stat.cur_hit) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_MARK;
               state_in   = S_MSTART;
            end else if (stat.nxt_end) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_IGNORED;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_LOAD;
            end
         end
         S_MSTART: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_zero = 1'b1;
            state_in    = S_MLOAD;
         end
         S_MLOAD: begin
            cmd.load_cur = 1'b1;
            state_in     = S_MCHK;
         end
         S_MCHK: begin
            if (stat.nxt_end) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_OK;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_MNXT;
            end
         end
         S_MNXT: begin
            if (stat.both_free) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_MERGE;
            end else begin
               cmd.load_cur = 1'b1;
            end
            state_in = S_MCHK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         free_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
